// ----- design/rds_pkg.sv -----
// Shared types, constants and helper functions for the stereo reverse delay.
// Used by the top level, rds_win and the bench; depends on nothing else.
package rds_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VSETUP,
      ST_VDIV,
      ST_VWIN,
      ST_VMUL1,
      ST_VMUL2,
      ST_VACC,
      ST_WET,
      ST_MIX,
      ST_FIN
   } state_type;

   localparam logic [1:0] CSR_SEGMENT  = 2'd0;
   localparam logic [1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [1:0] CSR_MIX      = 2'd2;
   localparam logic [1:0] CSR_DECAY    = 2'd3;

   localparam int unsigned SEG_MIN   = 64;
   localparam int unsigned FB_MAX    = 62259;
   localparam int unsigned UNITY     = 65536;
   localparam int unsigned GAIN_A    = 65536;
   localparam int unsigned GAIN_B    = 45875;
   localparam int unsigned DEC_BASE  = 19661;
   localparam int unsigned DEC_SPAN  = 45875;

   localparam logic [17:0] SEG_RESET = 18'd4800;
   localparam logic [15:0] FB_RESET  = 16'd0;
   localparam logic [16:0] MIX_RESET = 17'd32768;
   localparam logic [16:0] DEC_RESET = 17'd65536;

   localparam longint unsigned Q30_ONE = 64'd1 << 30;
   localparam longint unsigned PI_Q30  = 64'd3373259426;

   // Raised-cosine window entry, Q0.16, for a table of 2**log2n entries.
   function automatic logic [15:0] hann_value(int unsigned i, int unsigned log2n);
      longint unsigned n, j, x, x2, t, s, h;
      n  = 64'd1 << log2n;
      j  = (2 * 64'(i) <= n) ? 64'(i) : n - 64'(i);
      x  = (PI_Q30 * j) >> log2n;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      h  = (s * s + (64'd1 << 43)) >> 44;
      if (h > 64'd65535) h = 64'd65535;
      return h[15:0];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
      logic signed [23:0] r;
      if (v > 48'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -48'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ----- design/rds_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the stereo delay line.
module rds_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rds_win.sv -----
// Raised-cosine window table with a registered read.
// Depends on rds_pkg for the entry function.
module rds_win #(
   parameter int ENTRIES = 1024
) (
   input  logic                       clock,
   input  logic [$clog2(ENTRIES)-1:0] addr,
   output logic [15:0]                value
);

   localparam int AW = $clog2(ENTRIES);

   logic [15:0] tab [ENTRIES];
   logic [15:0] value_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_tab
      assign tab[i] = rds_pkg::hann_value(i, AW);
   end

   always_ff @(posedge clock) begin
      value_ff <= tab[addr];
   end

   assign value = value_ff;

endmodule

// ----- design/rds_div.sv -----
// Iterative restoring divider for the window index, one quotient bit a cycle.
// The dividend is below the divisor, so the quotient is a pure fraction.
module rds_div #(
   parameter int NW = 18,
   parameter int QW = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient
);

   localparam int CNTW = $clog2(QW + 1);

   logic [NW:0]     rem_ff, rem_in;
   logic [NW-1:0]   dvs_ff;
   logic [QW-1:0]   q_ff, q_in;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff;
   logic [NW:0]     shifted;
   logic            bit_set;

   always_comb begin
      shifted = {rem_ff[NW-1:0], 1'b0};
      bit_set = shifted >= {1'b0, dvs_ff};
      rem_in  = bit_set ? shifted - {1'b0, dvs_ff} : shifted;
      q_in    = {q_ff[QW-2:0], bit_set};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         dvs_ff <= divisor;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNTW'(QW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- design/reverse_delay_stereo.sv -----
// Top level of the stereo reverse delay: sequencer, voice state and arithmetic.
// Depends on rds_pkg, rds_ram, rds_win and rds_div.
//
//   group  direction  beat contents (lowest bits first)
//   req_   in         left_in[23:0], right_in[23:0]
//   rsp_   out        left_out[23:0], right_out[23:0]
//   csr_   in         register write: index, data (segment, feedback, mix, decay)
//
// A sample pair takes longer with both voices active than with idle voices, since each
// active voice runs the window-index divider.
// The delay line reads as zero until written, tracked by a fill count: no clearing pass.
// A finished result waits in the output register while the next beat is taken.
// Reset is synchronous and active high.
module reverse_delay_stereo #(
   parameter int LINE_DEPTH     = 131072,
   parameter int WINDOW_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // left_in, right_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // left_out, right_out
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [17:0] csr_wdata
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int QW = $clog2(WINDOW_ENTRIES);

   rds_pkg::state_type state_ff, state_in;

   logic [17:0] seg_cfg_ff;
   logic [15:0] fb_cfg_ff;
   logic [16:0] mix_cfg_ff;
   logic [16:0] dec_cfg_ff;

   logic [AW-1:0] widx_ff;
   logic [AW:0]   fill_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] a_rd_ff, b_rd_ff;
   logic [CW-1:0] a_left_ff, b_left_ff;
   logic          voice_ff;

   logic signed [23:0] dl_ff, dr_ff;
   logic [16:0]        dscale_ff;
   logic signed [25:0] acc_l_ff, acc_r_ff;
   logic [CW-1:0]      leftc_ff;
   logic               fwd_ff, valid_ff;
   logic signed [40:0] p_l_ff, p_r_ff;
   logic signed [58:0] g_l_ff, g_r_ff;
   logic signed [25:0] wet_l_ff, wet_r_ff;
   logic signed [41:0] pd_l_ff, pd_r_ff;
   logic signed [43:0] pw_l_ff, pw_r_ff;
   logic signed [42:0] pf_l_ff, pf_r_ff;
   logic               out_valid_ff;
   logic [47:0]        out_data_ff;

   logic [31:0]   seg_wide;
   logic [CW-1:0] seg_eff;
   logic [15:0]   fb_eff;
   logic [16:0]   mix_eff, dec_eff, dry;
   logic [CW-1:0] cur_left, leftc;
   logic [AW-1:0] cur_rd, rd_next, wp_next;
   logic [CW-1:0] count_inc;
   logic          out_free, accept;
   logic          ram_rd_en, ram_we, div_start, out_load;
   logic [47:0]   ram_rd_data, ram_wr_data;
   logic          div_done;
   logic [QW-1:0] win_idx;
   logic [15:0]   win_val;
   logic [32:0]   dec_prod;
   logic signed [23:0] samp_l, samp_r;
   logic signed [17:0] gain;
   logic signed [58:0] tg_l, tg_r;
   logic signed [43:0] m_l, m_r;
   logic signed [44:0] sum_l, sum_r;
   logic signed [42:0] tf_l, tf_r;
   logic signed [23:0] out_l, out_r, line_l, line_r;

   // Register values as used: clamped to their working ranges.
   always_comb begin
      seg_wide = 32'(seg_cfg_ff);
      if (seg_wide < rds_pkg::SEG_MIN) begin
         seg_eff = CW'(rds_pkg::SEG_MIN);
      end else if (seg_wide > 32'(LINE_DEPTH)) begin
         seg_eff = CW'(LINE_DEPTH);
      end else begin
         seg_eff = CW'(seg_wide);
      end
      fb_eff   = (32'(fb_cfg_ff) > rds_pkg::FB_MAX) ? 16'(rds_pkg::FB_MAX) : fb_cfg_ff;
      mix_eff  = (32'(mix_cfg_ff) > rds_pkg::UNITY) ? 17'(rds_pkg::UNITY) : mix_cfg_ff;
      dec_eff  = (32'(dec_cfg_ff) > rds_pkg::UNITY) ? 17'(rds_pkg::UNITY) : dec_cfg_ff;
      dry      = 17'(rds_pkg::UNITY) - mix_eff;
      dec_prod = 33'(rds_pkg::DEC_SPAN) * 33'(dec_eff) + 33'd32768;
   end

   always_comb begin
      cur_left  = voice_ff ? b_left_ff : a_left_ff;
      cur_rd    = voice_ff ? b_rd_ff : a_rd_ff;
      leftc     = (cur_left > seg_eff) ? seg_eff : cur_left;
      rd_next   = (cur_rd == '0) ? AW'(LINE_DEPTH - 1) : cur_rd - 1'b1;
      wp_next   = (widx_ff == AW'(LINE_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
      count_inc = count_ff + 1'b1;
      out_free  = !out_valid_ff || rsp_tready;
      accept    = req_tvalid && req_tready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rds_pkg::ST_IDLE:   if (req_tvalid) state_in = rds_pkg::ST_VSETUP;
         rds_pkg::ST_VSETUP: begin
            if (cur_left != '0) begin
               state_in = rds_pkg::ST_VDIV;
            end else if (voice_ff) begin
               state_in = rds_pkg::ST_WET;
            end
         end
         rds_pkg::ST_VDIV:   if (div_done) state_in = rds_pkg::ST_VWIN;
         rds_pkg::ST_VWIN:   state_in = rds_pkg::ST_VMUL1;
         rds_pkg::ST_VMUL1:  state_in = rds_pkg::ST_VMUL2;
         rds_pkg::ST_VMUL2:  state_in = rds_pkg::ST_VACC;
         rds_pkg::ST_VACC:   state_in = voice_ff ? rds_pkg::ST_WET : rds_pkg::ST_VSETUP;
         rds_pkg::ST_WET:    state_in = rds_pkg::ST_MIX;
         rds_pkg::ST_MIX:    state_in = rds_pkg::ST_FIN;
         rds_pkg::ST_FIN:    if (out_free) state_in = rds_pkg::ST_IDLE;
         default:            state_in = rds_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      ram_rd_en  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         rds_pkg::ST_IDLE:   req_tready = 1'b1;
         rds_pkg::ST_VSETUP: begin
            ram_rd_en = cur_left != '0;
            div_start = cur_left != '0;
         end
         rds_pkg::ST_FIN:    out_load = out_free;
         default:            req_tready = 1'b0;
      endcase
      ram_we = out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   rds_ram #(
      .WIDTH (48),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (widx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_rd),
      .rd_data (ram_rd_data)
   );

   rds_div #(
      .NW (CW),
      .QW (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (seg_eff - leftc),
      .divisor  (seg_eff),
      .done     (div_done),
      .quotient (win_idx)
   );

   rds_win #(
      .ENTRIES (WINDOW_ENTRIES)
   ) u_win (
      .clock (clock),
      .addr  (win_idx),
      .value (win_val)
   );

   // Arithmetic, stage by stage.
   always_comb begin
      if (fwd_ff) begin
         samp_l = dl_ff;
         samp_r = dr_ff;
      end else if (valid_ff) begin
         samp_l = ram_rd_data[23:0];
         samp_r = ram_rd_data[47:24];
      end else begin
         samp_l = '0;
         samp_r = '0;
      end
      gain  = voice_ff ? 18'sd45875 : 18'sd65536;
      tg_l  = g_l_ff + 59'sd2147483648;
      tg_r  = g_r_ff + 59'sd2147483648;
      m_l   = 44'(acc_l_ff) * 44'($signed({1'b0, dscale_ff})) + 44'sd32768;
      m_r   = 44'(acc_r_ff) * 44'($signed({1'b0, dscale_ff})) + 44'sd32768;
      sum_l = 45'(pd_l_ff) + 45'(pw_l_ff) + 45'sd32768;
      sum_r = 45'(pd_r_ff) + 45'(pw_r_ff) + 45'sd32768;
      tf_l  = pf_l_ff + 43'sd32768;
      tf_r  = pf_r_ff + 43'sd32768;
      out_l = rds_pkg::sat24(48'(sum_l >>> 16));
      out_r = rds_pkg::sat24(48'(sum_r >>> 16));
      line_l = rds_pkg::sat24(48'(dl_ff) + 48'(tf_l >>> 16));
      line_r = rds_pkg::sat24(48'(dr_ff) + 48'(tf_r >>> 16));
      ram_wr_data = {line_r, line_l};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dl_ff     <= req_tdata[23:0];
         dr_ff     <= req_tdata[47:24];
         dscale_ff <= 17'(rds_pkg::DEC_BASE) + dec_prod[32:16];
         acc_l_ff  <= '0;
         acc_r_ff  <= '0;
      end
      if (state_ff == rds_pkg::ST_VSETUP) begin
         leftc_ff <= leftc;
         fwd_ff   <= cur_rd == widx_ff;
         valid_ff <= {1'b0, cur_rd} < fill_ff;
      end
      if (state_ff == rds_pkg::ST_VMUL1) begin
         p_l_ff <= 41'(samp_l) * 41'($signed({1'b0, win_val}));
         p_r_ff <= 41'(samp_r) * 41'($signed({1'b0, win_val}));
      end
      if (state_ff == rds_pkg::ST_VMUL2) begin
         g_l_ff <= 59'(p_l_ff) * 59'(gain);
         g_r_ff <= 59'(p_r_ff) * 59'(gain);
      end
      if (state_ff == rds_pkg::ST_VACC) begin
         acc_l_ff <= acc_l_ff + tg_l[57:32];
         acc_r_ff <= acc_r_ff + tg_r[57:32];
      end
      if (state_ff == rds_pkg::ST_WET) begin
         wet_l_ff <= m_l[41:16];
         wet_r_ff <= m_r[41:16];
      end
      if (state_ff == rds_pkg::ST_MIX) begin
         pd_l_ff <= 42'(dl_ff) * 42'($signed({1'b0, dry}));
         pd_r_ff <= 42'(dr_ff) * 42'($signed({1'b0, dry}));
         pw_l_ff <= 44'(wet_l_ff) * 44'($signed({1'b0, mix_eff}));
         pw_r_ff <= 44'(wet_r_ff) * 44'($signed({1'b0, mix_eff}));
         pf_l_ff <= 43'(wet_l_ff) * 43'($signed({1'b0, fb_eff}));
         pf_r_ff <= 43'(wet_r_ff) * 43'($signed({1'b0, fb_eff}));
      end
      if (out_load) begin
         out_data_ff <= {out_r, out_l};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cfg_ff   <= rds_pkg::SEG_RESET;
         fb_cfg_ff    <= rds_pkg::FB_RESET;
         mix_cfg_ff   <= rds_pkg::MIX_RESET;
         dec_cfg_ff   <= rds_pkg::DEC_RESET;
         widx_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         a_rd_ff      <= '0;
         b_rd_ff      <= '0;
         a_left_ff    <= '0;
         b_left_ff    <= '0;
         voice_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            voice_ff <= 1'b0;
         end
         if (state_ff == rds_pkg::ST_VSETUP && cur_left == '0) begin
            voice_ff <= 1'b1;
         end
         if (state_ff == rds_pkg::ST_VACC) begin
            voice_ff <= 1'b1;
            if (voice_ff) begin
               b_rd_ff   <= rd_next;
               b_left_ff <= leftc_ff - 1'b1;
            end else begin
               a_rd_ff   <= rd_next;
               a_left_ff <= leftc_ff - 1'b1;
            end
         end
         if (rsp_tready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            widx_ff      <= wp_next;
            if (fill_ff != (AW + 1)'(LINE_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (count_inc >= seg_eff) begin
               count_ff  <= '0;
               a_rd_ff   <= widx_ff;
               a_left_ff <= seg_eff;
               if (b_left_ff == '0) begin
                  b_rd_ff   <= widx_ff;
                  b_left_ff <= seg_eff;
               end
            end else begin
               count_ff <= count_inc;
            end
         end
         if (csr_we) begin
            unique case (csr_addr)
               rds_pkg::CSR_SEGMENT: begin
                  seg_cfg_ff <= csr_wdata;
                  count_ff   <= '0;
                  a_left_ff  <= '0;
                  b_left_ff  <= '0;
               end
               rds_pkg::CSR_FEEDBACK: fb_cfg_ff  <= csr_wdata[15:0];
               rds_pkg::CSR_MIX:      mix_cfg_ff <= csr_wdata[16:0];
               rds_pkg::CSR_DECAY:    dec_cfg_ff <= csr_wdata[16:0];
               default:               fb_cfg_ff  <= fb_cfg_ff;
            endcase
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (AW + 1)'(LINE_DEPTH))
      else $error("Fill count beyond the line depth.");

   a_voice_bound: assert property (@(posedge clock) disable iff (reset)
      a_left_ff <= seg_eff && b_left_ff <= seg_eff)
      else $error("Voice has more samples left than a segment.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < seg_eff)
      else $error("Segment counter passed the segment length.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Beat accepted while the previous one is still at work.");

   a_write_at_end: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ram_rd_en && state_ff == rds_pkg::ST_FIN)
      else $error("Line write outside the final step.");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for reverse_delay_stereo: drives stereo sample beats,
// predicts every output pair and compares it with what the block returns.
// Depends on the design files and rds_pkg for the register indexes.
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH    = 131072;
   localparam int WIN_N    = 1024;
   localparam int WATCHDOG = 5000;
   localparam int HOLD_LEN = 600;

   typedef struct packed {
      logic signed [23:0] right;
      logic signed [23:0] left;
   } pair_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [17:0] csr_wdata = '0;

   reverse_delay_stereo uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Model of the block.
   int             line_l [DEPTH];
   int             line_r [DEPTH];
   logic [15:0]    hann [WIN_N];
   int unsigned    wr_ptr, seg_cnt, a_rd, a_left, b_rd, b_left;
   int unsigned    seg_reg, fb_reg, mix_reg, dec_reg;

   pair_t pending_pairs [$];
   pair_t expected_pairs [$];
   int    send_idle = 0, recv_stall = 0;
   bit    hold_on = 0;
   int    hold_count = 0;
   int    errors = 0;
   int    quiet = 0;

   function automatic logic [15:0] window_at(int unsigned i);
      longint unsigned j, x, x2, t, s, h;
      j  = (2 * i <= WIN_N) ? i : WIN_N - i;
      x  = (64'd3373259426 * j) / WIN_N;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      h  = (s * s + (64'd1 << 43)) >> 44;
      if (h > 65535) h = 65535;
      return h[15:0];
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   task automatic add_voice(inout int unsigned rd, inout int unsigned left,
                            input longint gain, input int unsigned seg,
                            inout longint wl, inout longint wr);
      int unsigned idx;
      longint w;
      if (left == 0) return;
      if (left > seg) left = seg;
      idx = int'((longint'(seg - left) * WIN_N) / seg);
      w = hann[idx % WIN_N];
      wl += round_shift(longint'(line_l[rd]) * w * gain, 32);
      wr += round_shift(longint'(line_r[rd]) * w * gain, 32);
      rd = (rd == 0) ? DEPTH - 1 : rd - 1;
      left -= 1;
   endtask

   task automatic predict_pair(input pair_t in);
      longint dl, dr, wl, wr, dscale;
      int unsigned seg, fb, mix, dec, wp;
      pair_t res;
      dl = in.left;
      dr = in.right;
      seg = (seg_reg < 64) ? 64 : (seg_reg > DEPTH) ? DEPTH : seg_reg;
      fb  = (fb_reg > 62259) ? 62259 : fb_reg;
      mix = (mix_reg > 65536) ? 65536 : mix_reg;
      dec = (dec_reg > 65536) ? 65536 : dec_reg;
      dscale = 19661 + round_shift(longint'(45875) * dec, 16);
      wl = 0;
      wr = 0;
      wp = wr_ptr;
      line_l[wp] = int'(dl);
      line_r[wp] = int'(dr);
      add_voice(a_rd, a_left, 65536, seg, wl, wr);
      add_voice(b_rd, b_left, 45875, seg, wl, wr);
      wl = round_shift(wl * dscale, 16);
      wr = round_shift(wr * dscale, 16);
      res.left  = 24'(clip24(round_shift(dl * (65536 - mix) + wl * mix, 16)));
      res.right = 24'(clip24(round_shift(dr * (65536 - mix) + wr * mix, 16)));
      expected_pairs.push_back(res);
      line_l[wp] = int'(clip24(dl + round_shift(wl * fb, 16)));
      line_r[wp] = int'(clip24(dr + round_shift(wr * fb, 16)));
      wr_ptr = (wp + 1) % DEPTH;
      seg_cnt += 1;
      if (seg_cnt >= seg) begin
         seg_cnt = 0;
         a_rd = wp;
         a_left = seg;
         if (b_left == 0) begin
            b_rd = wp;
            b_left = seg;
         end
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         rds_pkg::CSR_SEGMENT: begin
            seg_reg = val;
            seg_cnt = 0;
            a_left = 0;
            b_left = 0;
         end
         rds_pkg::CSR_FEEDBACK: fb_reg = val[15:0];
         rds_pkg::CSR_MIX: mix_reg = val[16:0];
         rds_pkg::CSR_DECAY: dec_reg = val[16:0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [17:0] seg, input logic [17:0] fb,
                            input logic [17:0] mix, input logic [17:0] dec);
      write_reg(rds_pkg::CSR_SEGMENT, seg);
      write_reg(rds_pkg::CSR_FEEDBACK, fb);
      write_reg(rds_pkg::CSR_MIX, mix);
      write_reg(rds_pkg::CSR_DECAY, dec);
      csr_we <= 0;
   endtask

   function automatic logic signed [23:0] rand_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return 24'sh7FFFFF;
      if (pick < 20) return 24'sh800000;
      if (pick < 35) return $signed(24'($urandom_range(511))) - 24'sd256;
      return 24'($urandom);
   endfunction

   task automatic queue_random(input int n);
      pair_t p;
      repeat (n) begin
         p.left = rand_sample();
         p.right = rand_sample();
         pending_pairs.push_back(p);
      end
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0 || req_tvalid || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_pair(pair_t'(req_tdata));
         if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_tdata <= pending_pairs.pop_front();
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Receiver, with the long hold-off counted here.
   always @(posedge clock) begin
      if (hold_on && hold_count < HOLD_LEN) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      pair_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
         end else begin
            want = expected_pairs.pop_front();
            if (got.left !== want.left) begin
               $display("%0t: left_out expected %0d actual %0d", $time, want.left, got.left);
               errors++;
            end
            if (got.right !== want.right) begin
               $display("%0t: right_out expected %0d actual %0d", $time, want.right,
                        got.right);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      pair_t p;
      for (int i = 0; i < WIN_N; i++) hann[i] = window_at(i);
      for (int i = 0; i < DEPTH; i++) begin
         line_l[i] = 0;
         line_r[i] = 0;
      end
      wr_ptr = 0; seg_cnt = 0; a_rd = 0; a_left = 0; b_rd = 0; b_left = 0;
      seg_reg = 4800; fb_reg = 0; mix_reg = 32768; dec_reg = 65536;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes with the shortest segment and full feedback.
      configure(18'd64, 18'd62259, 18'd32768, 18'd65536);
      for (int i = 0; i < 16; i++) begin
         p.left  = (i[0]) ? 24'sh7FFFFF : 24'sh800000;
         p.right = (i[1]) ? 24'sh7FFFFF : (i[2] ? 24'sh000000 : 24'sh800000);
         if (i[3]) p.left = -24'sd1;
         pending_pairs.push_back(p);
      end
      queue_random(64);
      drain();

      // Equal segment rewrite, feedback and mix registers above their ranges.
      configure(18'd64, 18'h0FFFF, 18'h1FFFF, 18'd0);
      queue_random(150);
      drain();

      send_idle = 88;
      configure(18'd0, 18'd0, 18'd0, 18'h1FFFF);
      queue_random(150);
      drain();

      send_idle = 0;
      recv_stall = 88;
      configure(18'd100, 18'd40000, 18'd20000, 18'd30000);
      queue_random(150);
      drain();

      send_idle = 22;
      recv_stall = 22;
      configure(18'h3FFFF, 18'd62259, 18'd65536, 18'd65536);
      queue_random(100);
      drain();

      send_idle = 0;
      recv_stall = 0;
      configure(18'd200, 18'd50000, 18'd45000, 18'd10000);
      hold_count = 0;
      hold_on = 1;
      queue_random(250);
      drain();
      hold_on = 0;

      send_idle = 22;
      recv_stall = 22;
      configure(18'd77, 18'($urandom_range(62259)), 18'($urandom_range(65536)),
                18'($urandom_range(65536)));
      queue_random(200);
      drain();

      send_idle = 0;
      recv_stall = 0;
      configure(18'd131072, 18'd1, 18'd65535, 18'd1);
      queue_random(60);
      drain();

      configure(18'd150, 18'd30000, 18'd50000, 18'd50000);
      queue_random(120);
      drain();

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
